// File: design/rtps_pkg.sv
// Package for the RTP/RTCP presentation-time synchroniser.
// Holds operation and status codes, sequencer states and widths. No dependencies.
`default_nettype none
package rtps_pkg;
  localparam int unsigned RateW = 31;
  localparam int unsigned PtW = 7;
  localparam int unsigned CfgW = 31;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] NsPerS = 32'd1000000000;

  typedef enum logic [1:0] {
    OP_RTP = 2'd0,
    OP_SR = 2'd1,
    OP_OTHER = 2'd2,
    OP_RSVD = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_SSRC = 2'd1,
    ST_BAD = 2'd2,
    ST_UNSORTED = 2'd3
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RTP_HZ = 2'd0,
    REG_PAYLOAD_TYPE = 2'd1,
    REG_SORTED_MODE = 2'd2,
    REG_NONE = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_BASE,
    S_MUL_A,
    S_MUL_B,
    S_NTP,
    S_OFFSET,
    S_DIV,
    S_APPLY,
    S_SORT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic [95:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
    logic [63:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

// File: design/rtps_div.sv
// Restoring divider: 96-bit dividend by 31-bit rate, one quotient bit a cycle.
// Depends on rtps_pkg. Flags overflow when the quotient exceeds 64 bits.
`default_nettype none
module rtps_div (
  input wire logic clk,
  input wire logic rst,
  input wire logic [rtps_pkg::RateW-1:0] rate,
  input wire rtps_pkg::div_req_t req,
  output rtps_pkg::div_rsp_t rsp
);
  import rtps_pkg::*;

  logic [95:0] dvd;
  logic [RateW:0] rem;
  logic [6:0] cnt;
  logic ovf;
  logic busy;
  logic done;
  logic [RateW+1:0] trial;

  assign trial = {rem, dvd[95]} - {2'b00, rate};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 7'd95) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      rem <= '0;
      cnt <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      cnt <= cnt + 7'd1;
      if (!trial[RateW+1]) begin
        rem <= trial[RateW:0];
        dvd <= {dvd[94:0], 1'b1};
        if (cnt < 7'd32) ovf <= 1'b1;
      end else begin
        rem <= {rem[RateW-1:0], dvd[95]};
        dvd <= {dvd[94:0], 1'b0};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.ovf = ovf;
  assign rsp.quot = dvd[63:0];
endmodule
`default_nettype wire

// File: design/rtp_rtcp_pts_synchronizer.sv
// Ignored ops and rejected packets go from S_DECODE to S_DONE; sender reports pass
// S_MUL_A, S_MUL_B, S_NTP; accepted RTP packets pass S_BASE, S_MUL_A, S_MUL_B,
// S_OFFSET, S_DIV, S_APPLY, S_SORT (a first base skips to S_SORT, a sorted repeat to
// S_DONE). One request at a time: ready is low from acceptance until the result is
// taken. Sync active-high reset clears sequencer and stream state; config regs to 0.
`default_nettype none
module rtp_rtcp_pts_synchronizer (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic [rtps_pkg::CfgIdxW-1:0] cfg_index,
  input wire logic [rtps_pkg::CfgW-1:0] cfg_data,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [1:0] op,
  input wire logic [31:0] ssrc,
  input wire logic [6:0] pkt_payload_type,
  input wire logic [31:0] media_timestamp,
  input wire logic [63:0] arrival_time,
  input wire logic [63:0] sr_ntp,
  output logic out_valid,
  input wire logic out_ready,
  output logic [63:0] pts_out,
  output logic [1:0] status
);
  import rtps_pkg::*;

  logic [RateW-1:0] rtp_hz;
  logic [PtW-1:0] payload_type;
  logic sorted_active;
  logic [63:0] ext_media_ts;
  logic [31:0] learned_ssrc;
  logic report_base_valid, interp_valid;
  logic [63:0] base_ntp_ns, base_arrival_ns, interp_base_ext_ts, interp_base_pts;
  logic [63:0] last_report_ext_ts, last_report_ntp_ns, prev_sorted_ext_ts, prev_sorted_pts;

  logic [1:0] r_op;
  logic [31:0] r_ssrc, r_mts;
  logic [6:0] r_pt;
  logic [63:0] r_arr, r_ntp;

  state_t state, state_next;
  logic [63:0] ext, pts, prod_a, prod_b, mag, ns;
  logic wdown, wup, neg, eqd;
  logic [1:0] st;
  div_req_t dreq;
  div_rsp_t drsp;
  logic ssrc_bad, pt_bad, sort_back, sort_repeat, interp_first;

  rtps_div u_div (.clk(clk), .rst(rst), .rate(rtp_hz), .req(dreq), .rsp(drsp));

  // wrap-aware extension
  logic [63:0] ext_r, ext_d, ext_calc;
  always_comb begin
    ext_r = {32'd0, r_mts} + {ext_media_ts[63:32], 32'd0};
    ext_d = (ext_r < ext_media_ts) ? ext_media_ts - ext_r : ext_r - ext_media_ts;
    ext_calc = ext_r;
    if (ext_media_ts == AllOnes) ext_calc = {32'd0, r_mts};
    else if (ext_d > 64'h7FFF_FFFF) begin
      if (ext_r < ext_media_ts) ext_calc = ext_r + 64'h1_0000_0000;
      else if (ext_r >= 64'h1_0000_0000) ext_calc = ext_r - 64'h1_0000_0000;
    end
  end

  assign ssrc_bad = (learned_ssrc != 32'd0) && (r_ssrc != learned_ssrc);
  assign pt_bad = (r_pt != payload_type) || (rtp_hz == '0);
  assign sort_back = sorted_active && (prev_sorted_ext_ts != AllOnes) &&
                     (ext < prev_sorted_ext_ts);
  assign sort_repeat = sorted_active && !sort_back && (ext == prev_sorted_ext_ts);
  assign interp_first = !report_base_valid && !interp_valid;

  // one 32x32 multiplier, shared
  logic [31:0] mul_x;
  logic [63:0] mul_p;
  assign mul_x = (state == S_MUL_A) ? (r_op == OP_SR ? r_ntp[31:0] : mag[31:0])
                                    : (r_op == OP_SR ? r_ntp[63:32] : mag[63:32]);
  assign mul_p = {32'd0, mul_x} * {32'd0, NsPerS};

  assign ns = prod_b + {32'd0, prod_a[63:32]};

  logic [63:0] dt, room;
  assign dt = drsp.ovf ? AllOnes : drsp.quot;
  assign room = ~pts;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    dreq.start = 1'b0;
    dreq.dividend = {prod_b + {32'd0, prod_a[63:32]}, prod_a[31:0]};
    in_ready = (state == S_IDLE);
    out_valid = (state == S_DONE);
    case (state)
      S_IDLE: if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (r_op == OP_SR) state_next = S_MUL_A;
        else if (r_op == OP_RTP && !ssrc_bad && !pt_bad) state_next = S_BASE;
        else state_next = S_DONE;
      end
      S_BASE: begin
        if (sort_repeat) state_next = S_DONE;
        else if (interp_first) state_next = S_SORT;
        else state_next = S_MUL_A;
      end
      S_MUL_A: state_next = S_MUL_B;
      S_MUL_B: state_next = (r_op == OP_SR) ? S_NTP : S_OFFSET;
      S_NTP: state_next = S_DONE;
      S_OFFSET: begin
        dreq.start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: if (drsp.done) state_next = S_APPLY;
      S_APPLY: state_next = S_SORT;
      S_SORT: state_next = S_DONE;
      S_DONE: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rtp_hz <= '0;
      payload_type <= '0;
      sorted_active <= 1'b0;
      ext_media_ts <= AllOnes;
      learned_ssrc <= '0;
      report_base_valid <= 1'b0;
      interp_valid <= 1'b0;
      base_ntp_ns <= AllOnes;
      base_arrival_ns <= AllOnes;
      interp_base_ext_ts <= AllOnes;
      interp_base_pts <= AllOnes;
      last_report_ext_ts <= AllOnes;
      last_report_ntp_ns <= AllOnes;
      prev_sorted_ext_ts <= AllOnes;
      prev_sorted_pts <= AllOnes;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_RTP_HZ: rtp_hz <= cfg_data[RateW-1:0];
          REG_PAYLOAD_TYPE: payload_type <= cfg_data[PtW-1:0];
          REG_SORTED_MODE: sorted_active <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (in_valid) begin
          r_op <= op; r_ssrc <= ssrc; r_pt <= pkt_payload_type;
          r_mts <= media_timestamp; r_arr <= arrival_time; r_ntp <= sr_ntp;
        end
        S_DECODE: begin
          pts <= r_arr;
          if (r_op == OP_SR) begin
            st <= ST_OK;
            ext_media_ts <= ext_calc;
            last_report_ext_ts <= ext_calc;
          end else if (r_op == OP_RTP) begin
            if (learned_ssrc == 32'd0) learned_ssrc <= r_ssrc;
            if (ssrc_bad) st <= ST_SSRC;
            else if (pt_bad) st <= ST_BAD;
            else begin
              st <= ST_OK;
              ext_media_ts <= ext_calc;
              ext <= ext_calc;
            end
          end else st <= ST_OK;
        end
        S_BASE: begin
          if (sort_back) begin
            sorted_active <= 1'b0;
            st <= ST_UNSORTED;
          end
          if (sort_repeat) begin
            if (prev_sorted_pts != AllOnes) pts <= prev_sorted_pts;
          end else if (!report_base_valid) begin
            wdown <= 1'b0; wup <= 1'b0;
            if (!interp_valid) begin
              interp_base_ext_ts <= ext;
              interp_base_pts <= r_arr;
              interp_valid <= 1'b1;
            end else pts <= interp_base_pts;
            neg <= ext < interp_base_ext_ts;
            eqd <= ext == interp_base_ext_ts;
            mag <= (ext < interp_base_ext_ts) ? interp_base_ext_ts - ext
                                              : ext - interp_base_ext_ts;
          end else begin
            if (last_report_ntp_ns > base_ntp_ns) begin
              wdown <= 1'b0;
              wup <= (last_report_ntp_ns - base_ntp_ns) > ~base_arrival_ns;
              pts <= base_arrival_ns + (last_report_ntp_ns - base_ntp_ns);
            end else if (last_report_ntp_ns < base_ntp_ns) begin
              wup <= 1'b0;
              wdown <= base_arrival_ns < (base_ntp_ns - last_report_ntp_ns);
              pts <= base_arrival_ns - (base_ntp_ns - last_report_ntp_ns);
            end else begin
              wdown <= 1'b0; wup <= 1'b0;
              pts <= base_arrival_ns;
            end
            neg <= ext < last_report_ext_ts;
            eqd <= ext == last_report_ext_ts;
            mag <= (ext < last_report_ext_ts) ? last_report_ext_ts - ext
                                              : ext - last_report_ext_ts;
          end
        end
        S_MUL_A: prod_a <= mul_p;
        S_MUL_B: prod_b <= mul_p;
        S_NTP: begin
          if (!report_base_valid) begin
            report_base_valid <= 1'b1;
            base_ntp_ns <= ns;
            base_arrival_ns <= r_arr;
          end
          last_report_ntp_ns <= ns;
        end
        S_APPLY: begin
          if (eqd) begin
            if (wdown) pts <= '0;
            else if (wup) pts <= AllOnes;
          end else if (!neg) begin
            if (wup) pts <= AllOnes;
            else if (wdown && dt < room) pts <= '0;
            else if (!wdown && dt > room) pts <= AllOnes;
            else pts <= pts + dt;
          end else begin
            if (wdown) pts <= '0;
            else if (wup && dt < pts) pts <= AllOnes;
            else if (!wup && dt > pts) pts <= '0;
            else pts <= pts - dt;
          end
        end
        S_SORT: begin
          if (sorted_active) begin
            if (prev_sorted_pts != AllOnes && pts < prev_sorted_pts) pts <= prev_sorted_pts;
            prev_sorted_ext_ts <= ext;
            prev_sorted_pts <= (prev_sorted_pts != AllOnes && pts < prev_sorted_pts)
                               ? prev_sorted_pts : pts;
          end
        end
        default: ;
      endcase
    end
  end

  assign pts_out = pts;
  assign status = st;
endmodule
`default_nettype wire

// File: test/rtps_checker.sv
// Checker for the RTP/RTCP presentation-time synchroniser: watches both channels and the
// register port, predicts each result and compares it field by field.
// Depends on rtps_pkg for op, status and register codes.
module rtps_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] ssrc,
  input  logic [6:0]  pkt_payload_type,
  input  logic [31:0] media_timestamp,
  input  logic [63:0] arrival_time,
  input  logic [63:0] sr_ntp,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] pts_out,
  input  logic [1:0]  status,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rtps_pkg::*;

  localparam logic [63:0] Ones = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] WrapStep = 64'h1_0000_0000;

  typedef struct {
    logic [63:0] pts;
    status_t     st;
  } pts_result_t;

  pts_result_t pts_due[$];

  logic [30:0] rate;
  logic [6:0]  accept_pt;

  logic [63:0] ext_ts;
  logic [31:0] known_ssrc;
  logic        sr_base_ok;
  logic [63:0] sr_base_ntp;
  logic [63:0] sr_base_arrival;
  logic        ip_ok;
  logic [63:0] ip_base_ts;
  logic [63:0] ip_base_pts;
  logic [63:0] sr_last_ts;
  logic [63:0] sr_last_ntp;
  logic        sorting;
  logic [63:0] mono_ts;
  logic [63:0] mono_pts;

  function automatic logic [63:0] extend_media(logic [31:0] ts);
    logic [63:0] r;
    logic [63:0] d;
    if (ext_ts == Ones) begin
      r = {32'd0, ts};
    end else begin
      r = {32'd0, ts} + {ext_ts[63:32], 32'd0};
      d = (r < ext_ts) ? ext_ts - r : r - ext_ts;
      if (d > 64'h7FFF_FFFF) begin
        if (r < ext_ts) r = r + WrapStep;
        else if (r >= WrapStep) r = r - WrapStep;
      end
    end
    ext_ts = r;
    return r;
  endfunction

  function automatic logic [63:0] ntp_ns(logic [63:0] ntp);
    logic [63:0] frac;
    frac = {32'd0, ntp[31:0]} * 64'd1000000000;
    return {32'd0, ntp[63:32]} * 64'd1000000000 + (frac >> 32);
  endfunction

  function automatic logic [63:0] ticks_to_ns(logic [63:0] v);
    logic [127:0] q;
    if (rate == 0) return Ones;
    q = ({64'd0, v} * 128'd1000000000) / {97'd0, rate};
    if (q[127:64] != 0) return Ones;
    return q[63:0];
  endfunction

  function automatic logic [63:0] shift_by_ticks(logic [63:0] p, logic [63:0] ext,
                                                 logic [63:0] base, logic wdown, logic wup);
    logic [63:0] dt;
    if (ext > base) begin
      dt = ticks_to_ns(ext - base);
      if (wup) return Ones;
      if (wdown && dt < Ones - p) return 0;
      if (!wdown && dt > Ones - p) return Ones;
      return p + dt;
    end
    if (ext < base) begin
      dt = ticks_to_ns(base - ext);
      if (wdown) return 0;
      if (wup && dt < p) return Ones;
      if (!wup && dt > p) return 0;
      return p - dt;
    end
    if (wdown) return 0;
    if (wup) return Ones;
    return p;
  endfunction

  function automatic pts_result_t predict_pts(op_t o, logic [31:0] s, logic [6:0] pt,
                                              logic [31:0] mts, logic [63:0] arr,
                                              logic [63:0] ntp);
    pts_result_t res;
    logic [63:0] p;
    logic [63:0] ext;
    logic [63:0] ns;
    logic [63:0] d;
    logic wdown;
    logic wup;
    res.pts = arr;
    res.st = ST_OK;
    p = arr;
    wdown = 1'b0;
    wup = 1'b0;
    if (o == OP_SR) begin
      ns = ntp_ns(ntp);
      if (!sr_base_ok) begin
        sr_base_ok = 1'b1;
        sr_base_ntp = ns;
        sr_base_arrival = arr;
      end
      sr_last_ts = extend_media(mts);
      sr_last_ntp = ns;
      return res;
    end
    if (o != OP_RTP) return res;
    if (known_ssrc == 0) begin
      known_ssrc = s;
    end else if (s != known_ssrc) begin
      res.st = ST_SSRC;
      return res;
    end
    if (pt != accept_pt || rate == 0) begin
      res.st = ST_BAD;
      return res;
    end
    ext = extend_media(mts);
    if (sorting) begin
      if (mono_ts != Ones && ext < mono_ts) begin
        sorting = 1'b0;
        res.st = ST_UNSORTED;
      end else if (ext == mono_ts) begin
        if (mono_pts != Ones) res.pts = mono_pts;
        return res;
      end
    end
    if (!sr_base_ok) begin
      if (!ip_ok) begin
        ip_base_ts = ext;
        ip_base_pts = arr;
        ip_ok = 1'b1;
      end else begin
        p = shift_by_ticks(ip_base_pts, ext, ip_base_ts, 1'b0, 1'b0);
      end
    end else begin
      p = sr_base_arrival;
      if (sr_last_ntp > sr_base_ntp) begin
        d = sr_last_ntp - sr_base_ntp;
        wup = d > Ones - p;
        p = p + d;
      end else if (sr_last_ntp < sr_base_ntp) begin
        d = sr_base_ntp - sr_last_ntp;
        wdown = p < d;
        p = p - d;
      end
      p = shift_by_ticks(p, ext, sr_last_ts, wdown, wup);
    end
    if (sorting) begin
      if (mono_pts != Ones && p < mono_pts) p = mono_pts;
      mono_ts = ext;
      mono_pts = p;
    end
    res.pts = p;
    return res;
  endfunction

  always @(posedge clk) begin
    pts_result_t want;
    if (rst) begin
      rate <= '0;
      accept_pt <= '0;
      fail_count = 0;
      ext_ts = Ones;
      known_ssrc = '0;
      sr_base_ok = 1'b0;
      sr_base_ntp = Ones;
      sr_base_arrival = Ones;
      ip_ok = 1'b0;
      ip_base_ts = Ones;
      ip_base_pts = Ones;
      sr_last_ts = Ones;
      sr_last_ntp = Ones;
      sorting = 1'b0;
      mono_ts = Ones;
      mono_pts = Ones;
      pts_due.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_RTP_HZ: rate <= cfg_data;
          REG_PAYLOAD_TYPE: accept_pt <= cfg_data[6:0];
          REG_SORTED_MODE: sorting = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pts_due.push_back(predict_pts(op_t'(op), ssrc, pkt_payload_type, media_timestamp,
                                      arrival_time, sr_ntp));
      if (out_valid && out_ready) begin
        if (pts_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: pts %h status %0d", pts_out, status);
        end else begin
          want = pts_due.pop_front();
          if (want.pts !== pts_out || want.st !== status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: pts exp %h got %h, status exp %0d got %0d",
                       want.pts, pts_out, want.st, status);
          end
        end
      end
    end
    pending = pts_due.size();
  end
endmodule

// File: test/tb_rtp_rtcp_pts_synchronizer.sv
// Testbench top for the RTP/RTCP presentation-time synchroniser: drives requests and
// register writes, stalls the result side, and gives the verdict.
// Depends on rtps_pkg, the block and rtps_checker.
module tb_rtp_rtcp_pts_synchronizer;
  timeunit 1ns;
  timeprecision 1ps;
  import rtps_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = '0;
  logic [31:0] ssrc = '0;
  logic [6:0]  pkt_payload_type = '0;
  logic [31:0] media_timestamp = '0;
  logic [63:0] arrival_time = '0;
  logic [63:0] sr_ntp = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] pts_out;
  logic [1:0]  status;
  int          fail_count;
  int          pending;

  logic        no_idle = 1'b0;
  logic [31:0] stream_ssrc;
  logic [6:0]  stream_pt;
  logic [31:0] cur_ts;
  logic [63:0] cur_arrival;
  logic [63:0] cur_ntp;

  always #6 clk = ~clk;

  rtp_rtcp_pts_synchronizer u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .ssrc(ssrc),
    .pkt_payload_type(pkt_payload_type), .media_timestamp(media_timestamp),
    .arrival_time(arrival_time), .sr_ntp(sr_ntp), .out_valid(out_valid),
    .out_ready(out_ready), .pts_out(pts_out), .status(status)
  );

  rtps_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .ssrc(ssrc),
    .pkt_payload_type(pkt_payload_type), .media_timestamp(media_timestamp),
    .arrival_time(arrival_time), .sr_ntp(sr_ntp), .out_valid(out_valid),
    .out_ready(out_ready), .pts_out(pts_out), .status(status),
    .fail_count(fail_count), .pending(pending)
  );

  task automatic send_request(op_t o, logic [31:0] s, logic [6:0] pt, logic [31:0] mts,
                              logic [63:0] arr, logic [63:0] ntp);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    ssrc <= s;
    pkt_payload_type <= pt;
    media_timestamp <= mts;
    arrival_time <= arr;
    sr_ntp <= ntp;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    @(posedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_mode(logic [30:0] r, logic [6:0] pt, logic srt);
    drain();
    write_reg(REG_RTP_HZ, r);
    write_reg(REG_PAYLOAD_TYPE, {24'd0, pt});
    write_reg(REG_SORTED_MODE, {30'd0, srt});
    stream_pt = pt;
  endtask

  task automatic random_request;
    int pick;
    logic [31:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      s = ($urandom_range(0, 1) != 0) ? stream_ssrc : $urandom;
      send_request(op_t'($urandom_range(0, 3)), s, 7'($urandom), $urandom,
                   {$urandom, $urandom}, {$urandom, $urandom});
    end else if (pick < 26) begin
      cur_ntp = cur_ntp + {32'd0, $urandom_range(0, 32'h4000_0000)};
      cur_arrival = cur_arrival + 64'($urandom_range(0, 50000000));
      send_request(OP_SR, stream_ssrc, stream_pt, cur_ts - 32'($urandom_range(0, 3000)),
                   cur_arrival, cur_ntp);
    end else if (pick < 30) begin
      send_request(OP_OTHER, stream_ssrc, stream_pt, cur_ts, cur_arrival, cur_ntp);
    end else begin
      if ($urandom_range(0, 9) == 0)
        cur_ts = cur_ts - 32'($urandom_range(1, 6000));
      else if ($urandom_range(0, 49) == 0)
        cur_ts = cur_ts + 32'($urandom_range(32'h7000_0000, 32'h9000_0000));
      else
        cur_ts = cur_ts + 32'($urandom_range(0, 3600));
      cur_arrival = cur_arrival + 64'($urandom_range(0, 40000000));
      send_request(OP_RTP, stream_ssrc, stream_pt, cur_ts, cur_arrival, cur_ntp);
    end
  endtask

  // result side: random stalls, one long hold-off
  initial begin
    int stall;
    int taken;
    taken = 0;
    wait (!rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (taken == 400) stall = 600;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
      taken++;
    end
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [30:0] rates[7];
    logic [6:0]  pts[7];
    logic        modes[7];
    rates = '{31'd90000, 31'd48000, 31'd1, 31'h7FFF_FFFF, 31'd0, 31'd8000, 31'd90000};
    pts = '{7'd96, 7'd111, 7'd0, 7'd127, 7'd96, 7'd96, 7'd8};
    modes = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    stream_ssrc = $urandom | 32'h1;
    cur_ts = $urandom;
    cur_arrival = {8'd0, $urandom, 24'd0};
    cur_ntp = {$urandom, $urandom} >> 2;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_mode(31'd90000, 7'd96, 1'b1);
    send_request(OP_OTHER, '1, '1, '1, '1, '1);
    send_request(OP_RSVD, '0, '0, '0, '0, '0);
    send_request(OP_RTP, 32'd0, 7'd96, 32'd1000, 64'd5000000, '0);
    send_request(OP_RTP, stream_ssrc, 7'd95, 32'd1000, 64'd6000000, '0);
    send_request(OP_RTP, stream_ssrc, 7'd96, 32'd1000, 64'd7000000, '0);
    send_request(OP_RTP, stream_ssrc, 7'd96, 32'd4000, 64'd8000000, '0);
    send_request(OP_RTP, stream_ssrc, 7'd96, 32'd500, 64'd9000000, '0);
    send_request(OP_RTP, stream_ssrc, 7'd96, 32'hFFFF_FF00, 64'd10000000, '0);
    send_request(OP_RTP, stream_ssrc, 7'd96, 32'h0000_0100, 64'd11000000, '0);
    send_request(OP_RTP, ~stream_ssrc, 7'd96, 32'h0000_0200, 64'd12000000, '0);
    send_request(OP_RTP, stream_ssrc, 7'd96, 32'hFFFF_FFFF, '1, '0);
    send_request(OP_SR, stream_ssrc, 7'd96, 32'h0000_0300, '1, '1);
    send_request(OP_RTP, stream_ssrc, 7'd96, 32'h0000_0400, 64'd0, '0);
    send_request(OP_SR, stream_ssrc, 7'd96, 32'h0000_0100, 64'd0, 64'd0);
    send_request(OP_RTP, stream_ssrc, 7'd96, 32'h0000_0500, 64'd3, '0);
    send_request(OP_RTP, stream_ssrc, 7'd96, 32'h0000_0000, 64'd3, '0);
    send_request(OP_SR, stream_ssrc, 7'd96, 32'h0000_0600, 64'd1000,
                 64'h8000_0000_8000_0000);
    send_request(OP_RTP, stream_ssrc, 7'd96, 32'h0000_0700, '0, '0);
    set_mode(31'd1, 7'd127, 1'b0);
    send_request(OP_RTP, stream_ssrc, 7'd127, 32'h8000_0000, 64'd1, '0);
    send_request(OP_RTP, stream_ssrc, 7'd127, 32'h0000_0000, 64'd1, '0);
    set_mode('0, 7'd127, 1'b0);
    send_request(OP_RTP, stream_ssrc, 7'd127, 32'h1234, 64'd1, '0);
    set_mode(31'h7FFF_FFFF, 7'd0, 1'b1);
    send_request(OP_RTP, stream_ssrc, 7'd0, 32'h5678, 64'd1, '0);

    cur_ts = 32'h0000_0800;
    for (int ph = 0; ph < 7; ph++) begin
      set_mode(rates[ph], pts[ph], modes[ph]);
      no_idle = (ph % 3 == 2);
      for (int n = 0; n < 270; n++) begin
        random_request();
        if (ph == 1 && n == 135) drain();
      end
      no_idle = 1'b0;
    end

    drain();
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
